// File: design/agap_pkg.sv
`default_nettype none

package agap_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_INT_OPEN  = 3'd0,
        CFG_INT_EXT   = 3'd1,
        CFG_TERM_OPEN = 3'd2,
        CFG_TERM_EXT  = 3'd3,
        CFG_ROWS_A    = 3'd4,
        CFG_COLS_B    = 3'd5
    } cfg_idx_t;

    // Match source and ending state codes
    typedef enum logic [1:0] {
        SRC_M = 2'd0,
        SRC_D = 2'd1,
        SRC_I = 2'd2
    } src_t;

    // Reset values of the configuration registers (penalties in Q7.8)
    localparam logic [15:0] INT_OPEN_RST  = 16'hFF26;  // -0.85
    localparam logic [15:0] INT_EXT_RST   = 16'hFFE6;  // -0.10
    localparam logic [15:0] TERM_OPEN_RST = 16'h0000;  //  0.0
    localparam logic [15:0] TERM_EXT_RST  = 16'hFFE6;  // -0.10
    localparam logic [15:0] ROWS_A_RST    = 16'd1;
    localparam logic [10:0] COLS_B_RST    = 11'd1;

    // Gap penalties, raw two's complement Q7.8
    typedef struct packed {
        logic [15:0] int_open;
        logic [15:0] int_ext;
        logic [15:0] term_open;
        logic [15:0] term_ext;
    } pen_t;

    // Per-cell position flags handed from the sequencer to the cell datapath
    typedef struct packed {
        logic first_row;
        logic last_row;
        logic first_col;
        logic at_end;
        logic fwd;       // row data comes from the write of the previous beat
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: design/agap_ram.sv
`default_nettype none

module agap_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: design/agap_seq.sv
`default_nettype none

module agap_seq import agap_pkg::*; #(
    parameter int MAX_COLS = 1024,
    localparam int AW = $clog2(MAX_COLS),
    localparam int CW = ((AW + 2) > 12) ? (AW + 2) : 12
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    // configuration writes
    input  wire logic          cfg_wr_en,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [15:0]   cfg_wdata,
    // input channel
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [15:0]   s_match_score,
    // compute stage
    input  wire logic          s1_advance,
    output logic               s1_valid,
    output cell_ctrl_t         s1_ctrl,
    output logic [AW-1:0]      s1_col,
    output logic [15:0]        s1_score,
    output pen_t               pen,
    // row memory read side
    output logic               rd_en,
    output logic [AW-1:0]      rd_addr
);

    logic [15:0]   int_open_reg, int_ext_reg, term_open_reg, term_ext_reg;
    logic [15:0]   rows_a_reg;
    logic [10:0]   cols_b_reg;

    logic [AW-1:0] col_idx_reg, col_idx_next;
    logic [15:0]   row_idx_reg, row_idx_next;
    logic          s1_valid_reg, s1_valid_next;
    cell_ctrl_t    s1_ctrl_reg;
    logic [AW-1:0] s1_col_reg;
    logic [15:0]   s1_score_reg;

    logic          accept;
    logic [15:0]   nrows;
    logic [CW-1:0] ncols_raw, ncols;
    logic          first_row, last_row, at_end;
    cell_ctrl_t    ctrl;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            int_open_reg  <= INT_OPEN_RST;
            int_ext_reg   <= INT_EXT_RST;
            term_open_reg <= TERM_OPEN_RST;
            term_ext_reg  <= TERM_EXT_RST;
            rows_a_reg    <= ROWS_A_RST;
            cols_b_reg    <= COLS_B_RST;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_INT_OPEN:  int_open_reg  <= cfg_wdata;
                CFG_INT_EXT:   int_ext_reg   <= cfg_wdata;
                CFG_TERM_OPEN: term_open_reg <= cfg_wdata;
                CFG_TERM_EXT:  term_ext_reg  <= cfg_wdata;
                CFG_ROWS_A:    rows_a_reg    <= cfg_wdata;
                CFG_COLS_B:    cols_b_reg    <= cfg_wdata[10:0];
                default: ;
            endcase
        end
    end

    // Stage 1 is free or empties this cycle
    assign s_ready = !s1_valid_reg || s1_advance;
    assign accept  = s_valid && s_ready;

    // Position of the accepted cell; zero lengths count as one
    always_comb begin
        nrows     = (rows_a_reg == 16'd0) ? 16'd1 : rows_a_reg;
        ncols_raw = (cols_b_reg == 11'd0) ? CW'(1) : CW'(cols_b_reg);
        ncols     = (ncols_raw > CW'(MAX_COLS)) ? CW'(MAX_COLS) : ncols_raw;
        first_row = (row_idx_reg == 16'd0);
        last_row  = ({1'b0, row_idx_reg} + 17'd1) >= {1'b0, nrows};
        at_end    = (CW'(col_idx_reg) + CW'(1)) >= ncols;

        ctrl.first_row = first_row;
        ctrl.last_row  = last_row;
        ctrl.first_col = (col_idx_reg == '0);
        ctrl.at_end    = at_end;
        // same column written by the beat leaving stage 1 (single-column rows)
        ctrl.fwd       = s1_advance && (s1_col_reg == col_idx_reg);
    end

    // Column and row counters
    always_comb begin
        col_idx_next = col_idx_reg;
        row_idx_next = row_idx_reg;
        if (accept) begin
            if (at_end) begin
                col_idx_next = '0;
                row_idx_next = last_row ? 16'd0 : row_idx_reg + 16'd1;
            end else begin
                col_idx_next = col_idx_reg + AW'(1);
            end
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_idx_reg  <= '0;
            row_idx_reg  <= 16'd0;
            s1_valid_reg <= 1'b0;
        end else begin
            col_idx_reg  <= col_idx_next;
            row_idx_reg  <= row_idx_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Stage 1 payload, loaded with the memory read
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_ctrl_reg  <= ctrl;
            s1_col_reg   <= col_idx_reg;
            s1_score_reg <= s_match_score;
        end
    end

    assign rd_en         = accept;
    assign rd_addr       = col_idx_reg;
    assign s1_valid      = s1_valid_reg;
    assign s1_ctrl       = s1_ctrl_reg;
    assign s1_col        = s1_col_reg;
    assign s1_score      = s1_score_reg;
    assign pen.int_open  = int_open_reg;
    assign pen.int_ext   = int_ext_reg;
    assign pen.term_open = term_open_reg;
    assign pen.term_ext  = term_ext_reg;

endmodule

`default_nettype wire

// File: design/agap_cell.sv
`default_nettype none

module agap_cell import agap_pkg::*; #(
    parameter int SCORE_BITS = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s1_valid,
    input  wire cell_ctrl_t            s1_ctrl,
    input  wire logic [15:0]           s1_score,
    input  wire pen_t                  pen,
    input  wire logic [SCORE_BITS-1:0] rd_match,
    input  wire logic [SCORE_BITS-1:0] rd_delete,
    output logic                       s1_advance,
    output logic [SCORE_BITS-1:0]      wr_match,
    output logic [SCORE_BITS-1:0]      wr_delete,
    // result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [3:0]                 m_cell_trace,
    output logic                       m_row_end,
    output logic                       m_edge_delete_trace,
    output logic                       m_last_row_valid,
    output logic                       m_last_row_trace,
    output logic                       m_done_res,
    output logic [31:0]                m_final_score,
    output logic [1:0]                 m_final_state
);

    localparam int SB = SCORE_BITS;
    localparam int EW = (SB > 32) ? SB : 33;
    localparam logic signed [SB-1:0] NEG_INF = {1'b1, {(SB-1){1'b0}}};
    localparam logic signed [SB-1:0] NEG_P1  = {1'b1, {(SB-2){1'b0}}, 1'b1};
    localparam logic signed [SB-1:0] SMAX    = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [EW-1:0] I32_MAX = EW'(64'sd2147483647);
    localparam logic signed [EW-1:0] I32_MINP1 = EW'(-64'sd2147483647);

    // Saturating add; minus infinity stays put
    function automatic logic signed [SB-1:0] sat_add(
        input logic signed [SB-1:0] s,
        input logic signed [15:0]   d
    );
        logic signed [SB:0] r;
        r = (SB+1)'(s) + (SB+1)'(d);
        if (s == NEG_INF) begin
            return NEG_INF;
        end else if (r[SB] != r[SB-1]) begin
            return r[SB] ? NEG_P1 : SMAX;
        end else if (r[SB-1:0] == NEG_INF) begin
            return NEG_P1;
        end else begin
            return r[SB-1:0];
        end
    endfunction

    logic signed [SB-1:0] diag_reg, ins_reg, last_ins_reg, edge_del_reg;
    logic signed [SB-1:0] fwd_m_reg, fwd_d_reg;

    logic                 m_valid_reg, m_valid_next;
    logic [3:0]           trace_reg;
    logic                 row_end_reg, edge_tr_reg, lvalid_reg, ltrace_reg, done_reg;
    logic [31:0]          fscore_reg;
    logic [1:0]           fstate_reg;

    logic signed [SB-1:0] mprev, dprev, m0, i0, xm, newm;
    logic signed [SB-1:0] md, dd, dnew, mi, ii, insn;
    logic signed [SB-1:0] lm, li, li_new, dedge, em, ed, ednew, best;
    logic signed [15:0]   open_b, ext_b, open_a, ext_a, t_open, t_ext;
    logic signed [EW-1:0] best_w;
    src_t                 src, fstate;
    logic                 del_open, ins_open, lr_act, lt, edge_tr, done;
    logic [31:0]          fscore;

    assign s1_advance = s1_valid && (!m_valid_reg || m_ready);

    // One cell: match, delete, insert, plus right-edge and last-row chains
    always_comb begin
        t_open = $signed(pen.term_open);
        t_ext  = $signed(pen.term_ext);
        mprev  = s1_ctrl.first_row ? NEG_INF :
                 (s1_ctrl.fwd ? fwd_m_reg : $signed(rd_match));
        dprev  = s1_ctrl.first_row ? NEG_INF :
                 (s1_ctrl.fwd ? fwd_d_reg : $signed(rd_delete));
        m0     = diag_reg;
        i0     = ins_reg;

        // match from the best predecessor, ties keep M then D
        xm  = m0;
        src = SRC_M;
        if (dprev > xm) begin
            xm  = dprev;
            src = SRC_D;
        end
        if (i0 > xm) begin
            xm  = i0;
            src = SRC_I;
        end
        newm = sat_add(xm, $signed(s1_score));

        // delete, terminal penalties in the first column
        open_b   = s1_ctrl.first_col ? t_open : $signed(pen.int_open);
        ext_b    = s1_ctrl.first_col ? t_ext  : $signed(pen.int_ext);
        md       = sat_add(m0, open_b);
        dd       = sat_add(dprev, ext_b);
        del_open = (md >= dd);
        dnew     = del_open ? md : dd;

        // insert, terminal penalties in the first row
        open_a   = s1_ctrl.first_row ? t_open : $signed(pen.int_open);
        ext_a    = s1_ctrl.first_row ? t_ext  : $signed(pen.int_ext);
        mi       = sat_add(m0, open_a);
        ii       = sat_add(i0, ext_a);
        ins_open = (mi >= ii);
        insn     = ins_open ? mi : ii;

        // last-row insert chain, strict compare
        lr_act = s1_ctrl.last_row && !s1_ctrl.at_end;
        lm     = sat_add(newm, t_open);
        li     = sat_add(last_ins_reg, t_ext);
        lt     = (lm > li);
        li_new = lt ? lm : li;

        // right-edge delete
        dedge   = s1_ctrl.first_row ? NEG_INF : edge_del_reg;
        em      = sat_add(mprev, t_open);
        ed      = sat_add(dedge, t_ext);
        edge_tr = (em >= ed);
        ednew   = edge_tr ? em : ed;

        // best end score
        best   = newm;
        fstate = SRC_M;
        if (ednew > best) begin
            best   = ednew;
            fstate = SRC_D;
        end
        if (last_ins_reg > best) begin
            best   = last_ins_reg;
            fstate = SRC_I;
        end
        best_w = EW'(best);
        if (best == NEG_INF) begin
            fscore = 32'h8000_0000;
        end else if (best_w > I32_MAX) begin
            fscore = 32'h7FFF_FFFF;
        end else if (best_w < I32_MINP1) begin
            fscore = 32'h8000_0001;
        end else begin
            fscore = best_w[31:0];
        end
        done = s1_ctrl.at_end && s1_ctrl.last_row;
    end

    assign wr_match  = newm;
    assign wr_delete = dnew;

    // Running scores
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diag_reg     <= '0;
            ins_reg      <= NEG_INF;
            last_ins_reg <= NEG_INF;
        end else if (s1_advance) begin
            if (s1_ctrl.at_end && s1_ctrl.last_row) begin
                diag_reg     <= '0;
                ins_reg      <= NEG_INF;
                last_ins_reg <= NEG_INF;
            end else if (s1_ctrl.at_end) begin
                diag_reg <= NEG_INF;
                ins_reg  <= NEG_INF;
            end else begin
                diag_reg <= mprev;
                ins_reg  <= insn;
                if (lr_act) begin
                    last_ins_reg <= li_new;
                end
            end
        end
    end

    // Edge delete and forwarding copies of the row write
    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            fwd_m_reg <= newm;
            fwd_d_reg <= dnew;
            if (s1_ctrl.at_end) begin
                edge_del_reg <= ednew;
            end
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            trace_reg   <= {ins_open, del_open, src};
            row_end_reg <= s1_ctrl.at_end;
            edge_tr_reg <= s1_ctrl.at_end && edge_tr;
            lvalid_reg  <= lr_act;
            ltrace_reg  <= lr_act && lt;
            done_reg    <= done;
            fscore_reg  <= done ? fscore : 32'd0;
            fstate_reg  <= done ? fstate : SRC_M;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_cell_trace        = trace_reg;
    assign m_row_end           = row_end_reg;
    assign m_edge_delete_trace = edge_tr_reg;
    assign m_last_row_valid    = lvalid_reg;
    assign m_last_row_trace    = ltrace_reg;
    assign m_done_res          = done_reg;
    assign m_final_score       = fscore_reg;
    assign m_final_state       = fstate_reg;

`ifndef SYNTHESIS
    // final cell always closes a row
    a_done_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_done_res) |-> m_row_end)
        else $error("done without row_end");

    // last-row insert trace never on the closing cell
    a_lrow_not_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_row_end && m_last_row_valid))
        else $error("last-row trace on row end");

    // a beat leaving stage 1 is presented next cycle
    a_advance_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_advance |=> m_valid)
        else $error("result lost");

    // running insert restarts at each row end
    a_ins_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_advance && s1_ctrl.at_end) |=> (ins_reg == NEG_INF))
        else $error("insert not restarted");
`endif

endmodule

`default_nettype wire

// File: design/affine_gap_alignment_dp_unit.sv
// An accepted beat is held in the stage 1 register, its result in the output register.
// Throughput: one cell per cycle while m_ready is high; set by the add-compare chain of the
//   cell datapath and the one-read/one-write row memories for M and D scores.
// Reset (aresetn low, synchronous): counters, running scores and handshake state
//   clear, configuration returns to defaults. Row memories are not cleared; the first row
//   of each alignment discards what it reads from them, so no clearing pass is needed.
`default_nettype none

module affine_gap_alignment_dp_unit import agap_pkg::*; #(
    parameter int MAX_COLS   = 1024,
    parameter int SCORE_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    // cell scores in
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_match_score,
    // trace results out
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_cell_trace,
    output logic             m_row_end,
    output logic             m_edge_delete_trace,
    output logic             m_last_row_valid,
    output logic             m_last_row_trace,
    output logic             m_done_res,
    output logic [31:0]      m_final_score,
    output logic [1:0]       m_final_state
);

    localparam int AW = $clog2(MAX_COLS);

    logic                  s1_advance, s1_valid, rd_en;
    cell_ctrl_t            s1_ctrl;
    logic [AW-1:0]         s1_col, rd_addr;
    logic [15:0]           s1_score;
    pen_t                  pen;
    logic [SCORE_BITS-1:0] rd_match, rd_delete, wr_match, wr_delete;

    // Sequencer: configuration, position counters, read issue
    agap_seq #(
        .MAX_COLS (MAX_COLS)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_match_score (s_match_score),
        .s1_advance    (s1_advance),
        .s1_valid      (s1_valid),
        .s1_ctrl       (s1_ctrl),
        .s1_col        (s1_col),
        .s1_score      (s1_score),
        .pen           (pen),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr)
    );

    // Previous-row match scores
    agap_ram #(
        .WIDTH (SCORE_BITS),
        .DEPTH (MAX_COLS)
    ) u_match_row (
        .aclk    (aclk),
        .wr_en   (s1_advance),
        .wr_addr (s1_col),
        .wr_data (wr_match),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_match)
    );

    // Previous-row delete scores
    agap_ram #(
        .WIDTH (SCORE_BITS),
        .DEPTH (MAX_COLS)
    ) u_delete_row (
        .aclk    (aclk),
        .wr_en   (s1_advance),
        .wr_addr (s1_col),
        .wr_data (wr_delete),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_delete)
    );

    // Cell datapath and output register
    agap_cell #(
        .SCORE_BITS (SCORE_BITS)
    ) u_cell (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s1_valid            (s1_valid),
        .s1_ctrl             (s1_ctrl),
        .s1_score            (s1_score),
        .pen                 (pen),
        .rd_match            (rd_match),
        .rd_delete           (rd_delete),
        .s1_advance          (s1_advance),
        .wr_match            (wr_match),
        .wr_delete           (wr_delete),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_cell_trace        (m_cell_trace),
        .m_row_end           (m_row_end),
        .m_edge_delete_trace (m_edge_delete_trace),
        .m_last_row_valid    (m_last_row_valid),
        .m_last_row_trace    (m_last_row_trace),
        .m_done_res          (m_done_res),
        .m_final_score       (m_final_score),
        .m_final_state       (m_final_state)
    );

endmodule

`default_nettype wire

// File: verif/tb_affine_gap_alignment_dp_unit.sv
`default_nettype none

module tb_affine_gap_alignment_dp_unit;
    import agap_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_COLS  = 1024;
    localparam int unsigned LIMIT     = 200000;
    localparam longint      SC_MAX    = 64'sd2147483647;
    localparam longint      SC_NEGINF = -64'sd2147483648;

    // One result beat, field for field
    typedef struct packed {
        logic [3:0]  cell_trace;
        logic        row_end;
        logic        edge_delete_trace;
        logic        last_row_valid;
        logic        last_row_trace;
        logic        done_res;
        logic [31:0] final_score;
        logic [1:0]  final_state;
    } trace_beat_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [2:0]  cfg_index     = '0;
    logic [15:0] cfg_wdata     = '0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [15:0] s_match_score = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [3:0]  m_cell_trace;
    logic        m_row_end;
    logic        m_edge_delete_trace;
    logic        m_last_row_valid;
    logic        m_last_row_trace;
    logic        m_done_res;
    logic [31:0] m_final_score;
    logic [1:0]  m_final_state;

    affine_gap_alignment_dp_unit uut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_match_score       (s_match_score),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_cell_trace        (m_cell_trace),
        .m_row_end           (m_row_end),
        .m_edge_delete_trace (m_edge_delete_trace),
        .m_last_row_valid    (m_last_row_valid),
        .m_last_row_trace    (m_last_row_trace),
        .m_done_res          (m_done_res),
        .m_final_score       (m_final_score),
        .m_final_state       (m_final_state)
    );

    always #6 aclk = ~aclk;

    // Stimulus and scoreboard bookkeeping
    logic [15:0]  cell_q[$];
    trace_beat_t  trace_q[$];
    int unsigned  cells_issued = 0;
    int unsigned  beats_seen   = 0;
    int unsigned  errors       = 0;
    int unsigned  cycle_count  = 0;
    bit           no_gaps      = 1'b0;
    bit           hold_req     = 1'b0;
    bit           hold_done    = 1'b0;
    int unsigned  hold_left    = 0;

    // Shadow configuration, reset values
    logic signed [15:0] gap_open_int  = -16'sd218;
    logic signed [15:0] gap_ext_int   = -16'sd26;
    logic signed [15:0] gap_open_term = 16'sd0;
    logic signed [15:0] gap_ext_term  = -16'sd26;
    logic [15:0]        rows_cfg      = 16'd1;
    logic [10:0]        cols_cfg      = 11'd1;

    // Shadow DP state: one row of M and D, plus running scores
    longint      m_row [0:MAX_COLS-1];
    longint      d_row [0:MAX_COLS];
    longint      diag_m = 0;
    longint      run_i  = SC_NEGINF;
    longint      last_i = SC_NEGINF;
    logic [15:0] row_idx = '0;
    logic [9:0]  col_idx = '0;

    initial begin
        foreach (m_row[k]) m_row[k] = 0;
        foreach (d_row[k]) d_row[k] = 0;
    end

    // Minus infinity is sticky; finite sums clamp short of it
    function automatic longint sat_add(longint s, longint d);
        longint r;
        if (s == SC_NEGINF) return SC_NEGINF;
        r = s + d;
        if (r > SC_MAX) return SC_MAX;
        if (r < SC_NEGINF + 1) return SC_NEGINF + 1;
        return r;
    endfunction

    // Advance the DP by one cell and return the beat it produces
    function automatic trace_beat_t gotoh_cell(logic [15:0] raw);
        trace_beat_t r;
        int unsigned nrows, ncols, j;
        bit     first_row, last_row, at_end, d_open, i_open;
        src_t   src;
        longint sc, m0, mprev, dprev, i0, xm, newm, md, d, mi, ins;
        longint g_open, g_ext, lm, li, dedge, em, ed, best;
        r = '0;
        sc = longint'($signed(raw));
        nrows = (rows_cfg == 0) ? 1 : rows_cfg;
        ncols = (cols_cfg == 0) ? 1 : cols_cfg;
        if (ncols > MAX_COLS) ncols = MAX_COLS;
        j = 32'(col_idx);
        first_row = (row_idx == 0);
        last_row  = (32'(row_idx) + 1 >= nrows);
        at_end    = (j + 1 >= ncols);

        m0    = diag_m;
        mprev = first_row ? SC_NEGINF : m_row[j];
        dprev = first_row ? SC_NEGINF : d_row[j];
        i0    = run_i;

        // match: best predecessor on the diagonal
        src = SRC_M;
        xm  = m0;
        if (dprev > xm) begin xm = dprev; src = SRC_D; end
        if (i0 > xm) begin xm = i0; src = SRC_I; end
        newm = sat_add(xm, sc);
        m_row[j] = newm;
        diag_m = mprev;

        // delete: terminal penalties in the first column
        g_open = (j == 0) ? gap_open_term : gap_open_int;
        g_ext  = (j == 0) ? gap_ext_term  : gap_ext_int;
        md = sat_add(m0, g_open);
        d  = sat_add(dprev, g_ext);
        d_open = (md >= d);
        if (d_open) d = md;
        d_row[j] = d;

        // insert: terminal penalties in the first row
        g_open = first_row ? gap_open_term : gap_open_int;
        g_ext  = first_row ? gap_ext_term  : gap_ext_int;
        mi  = sat_add(m0, g_open);
        ins = sat_add(i0, g_ext);
        i_open = (mi >= ins);
        if (i_open) ins = mi;
        run_i = ins;

        r.cell_trace = {i_open, d_open, src};
        r.row_end = at_end;

        // last-row insert chain, strict compare
        if (last_row && !at_end) begin
            lm = sat_add(newm, gap_open_term);
            li = sat_add(last_i, gap_ext_term);
            r.last_row_valid = 1'b1;
            r.last_row_trace = (lm > li);
            if (lm > li) li = lm;
            last_i = li;
        end

        if (at_end) begin
            dedge = first_row ? SC_NEGINF : d_row[ncols];
            em = sat_add(diag_m, gap_open_term);
            ed = sat_add(dedge, gap_ext_term);
            r.edge_delete_trace = (em >= ed);
            if (em >= ed) ed = em;
            d_row[ncols] = ed;
            if (last_row) begin
                best = newm;
                r.final_state = SRC_M;
                if (ed > best) begin best = ed; r.final_state = SRC_D; end
                if (last_i > best) begin best = last_i; r.final_state = SRC_I; end
                // 32-bit scores: minus infinity already sits on the most negative code
                r.final_score = best[31:0];
                r.done_res = 1'b1;
                diag_m  = 0;
                run_i   = SC_NEGINF;
                last_i  = SC_NEGINF;
                row_idx = '0;
                col_idx = '0;
            end else begin
                diag_m  = SC_NEGINF;
                run_i   = SC_NEGINF;
                col_idx = '0;
                row_idx = row_idx + 16'd1;
            end
        end else begin
            col_idx = 10'(j + 1);
        end
        return r;
    endfunction

    // Driver: offers queued cell scores, predicts on each accepted beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                trace_q.push_back(gotoh_cell(s_match_score));
            if (!s_valid || s_ready) begin
                if (cell_q.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 36)) begin
                    s_valid <= 1'b1;
                    s_match_score <= cell_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic cmp_field(string fname, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
        end
    endtask

    // Monitor: ready pattern, long hold-off once, compare against oldest prediction
    always @(posedge aclk) begin
        trace_beat_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                beats_seen++;
                if (trace_q.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with nothing expected, trace %0h", $time,
                             m_cell_trace);
                end else begin
                    want = trace_q.pop_front();
                    cmp_field("cell_trace", 32'(want.cell_trace), 32'(m_cell_trace));
                    cmp_field("row_end", 32'(want.row_end), 32'(m_row_end));
                    cmp_field("edge_delete_trace", 32'(want.edge_delete_trace),
                              32'(m_edge_delete_trace));
                    cmp_field("last_row_valid", 32'(want.last_row_valid),
                              32'(m_last_row_valid));
                    cmp_field("last_row_trace", 32'(want.last_row_trace),
                              32'(m_last_row_trace));
                    cmp_field("done_res", 32'(want.done_res), 32'(m_done_res));
                    cmp_field("final_score", want.final_score, m_final_score);
                    cmp_field("final_state", 32'(want.final_state), 32'(m_final_state));
                end
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_done <= 1'b1;
                hold_left <= 90;
                m_ready <= 1'b0;
            end else begin
                m_ready <= no_gaps || ($urandom_range(0, 99) >= 36);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("tb_affine_gap_alignment_dp_unit NOT OK");
            $finish;
        end
    end

    // Register write; shadow copy follows once the beat has landed
    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_INT_OPEN:  gap_open_int  = val;
            CFG_INT_EXT:   gap_ext_int   = val;
            CFG_TERM_OPEN: gap_open_term = val;
            CFG_TERM_EXT:  gap_ext_term  = val;
            CFG_ROWS_A:    rows_cfg      = val;
            CFG_COLS_B:    cols_cfg      = val[10:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic push_cell(logic [15:0] v);
        cell_q.push_back(v);
        cells_issued++;
    endtask

    // Every cell gives exactly one beat, so idle means all beats are back
    task automatic wait_idle();
        do @(posedge aclk); while (beats_seen != cells_issued);
    endtask

    function automatic logic [15:0] rand_penalty();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'h8000;
            2, 3:    return 16'(0 - $urandom_range(0, 32768));
            default: return 16'(0 - $urandom_range(0, 600));
        endcase
    endfunction

    function automatic logic [15:0] rand_score();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3, 4: return 16'(int'($urandom_range(0, 1200)) - 600);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_alignment(int unsigned rows, int unsigned cols);
        int unsigned nr, nc;
        nr = (rows == 0) ? 1 : rows;
        nc = (cols == 0) ? 1 : ((cols > MAX_COLS) ? MAX_COLS : cols);
        write_reg(CFG_ROWS_A, 16'(rows));
        write_reg(CFG_COLS_B, 16'(cols));
        repeat (nr * nc) push_cell(rand_score());
        wait_idle();
    endtask

    initial begin
        int unsigned phase;
        int unsigned rows, cols;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults, 1x1
        push_cell(16'h7FFF);
        wait_idle();

        // 2x4 with extreme penalties and scores
        write_reg(CFG_INT_OPEN, 16'h8000);
        write_reg(CFG_INT_EXT, 16'h0000);
        write_reg(CFG_TERM_OPEN, 16'hFFF3);
        write_reg(CFG_TERM_EXT, 16'h8000);
        write_reg(CFG_ROWS_A, 16'd2);
        write_reg(CFG_COLS_B, 16'd4);
        push_cell(16'h7FFF);
        push_cell(16'h8000);
        push_cell(16'h0000);
        push_cell(16'h0100);
        push_cell(16'hFF00);
        push_cell(16'h7FFF);
        push_cell(16'h8000);
        push_cell(16'h0001);
        wait_idle();

        // zero lengths count as one
        write_reg(CFG_ROWS_A, 16'd0);
        write_reg(CFG_COLS_B, 16'd0);
        push_cell(16'h5A5A);
        wait_idle();

        // cols shrink mid first row: column already past the end closes the row
        write_reg(CFG_ROWS_A, 16'd2);
        write_reg(CFG_COLS_B, 16'd8);
        repeat (6) push_cell(rand_score());
        wait_idle();
        write_reg(CFG_COLS_B, 16'd3);
        push_cell(rand_score());
        wait_idle();
        repeat (3) push_cell(rand_score());
        wait_idle();

        // rows shrink below the current row: that row is the last one
        write_reg(CFG_ROWS_A, 16'hFFFF);
        write_reg(CFG_COLS_B, 16'd1);
        repeat (4) push_cell(rand_score());
        wait_idle();
        write_reg(CFG_ROWS_A, 16'd2);
        push_cell(rand_score());
        wait_idle();

        // random alignments, mostly small, one past the column limit at full width
        phase = 0;
        while (phase <= 8 || cells_issued < 1650) begin
            write_reg(CFG_INT_OPEN, rand_penalty());
            write_reg(CFG_INT_EXT, rand_penalty());
            write_reg(CFG_TERM_OPEN, rand_penalty());
            write_reg(CFG_TERM_EXT, rand_penalty());
            if (phase == 8) begin
                rows = 1;
                cols = 2047;
                no_gaps = 1'b1;
            end else if (phase == 4) begin
                rows = 4;
                cols = 40;
                hold_req = 1'b1;
            end else if ($urandom_range(0, 9) == 0) begin
                rows = $urandom_range(0, 2);
                cols = $urandom_range(0, 3);
            end else if ($urandom_range(0, 7) == 0) begin
                rows = $urandom_range(1, 3);
                cols = $urandom_range(11, 64);
            end else begin
                rows = $urandom_range(1, 6);
                cols = $urandom_range(1, 10);
            end
            run_alignment(rows, cols);
            no_gaps = 1'b0;
            phase++;
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (errors == 0 && trace_q.size() == 0) begin
            $display("tb_affine_gap_alignment_dp_unit OK");
        end else begin
            $display("tb_affine_gap_alignment_dp_unit NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
